>>> design/gcw_pkg.sv
// Shared types and constants of the banked GPIO controller.
package gcw_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    KIND_LEVEL  = 4'd0,
    KIND_DIR    = 4'd1,
    KIND_SET    = 4'd2,
    KIND_CLR    = 4'd3,
    KIND_RISE   = 4'd4,
    KIND_FALL   = 4'd5,
    KIND_BYPASS = 4'd6,
    KIND_MASK   = 4'd7,
    KIND_SRC    = 4'd8,
    KIND_TYPE   = 4'd9,
    KIND_POL    = 4'd10,
    KIND_WMASK  = 4'd11,
    KIND_WSRC   = 4'd12
  } kind_e;

  localparam int unsigned KindCount = 13;
  localparam int unsigned PinsPerBank = 32;

  localparam logic [11:0] KindBase [KindCount] = '{
    12'h004, 12'h01c, 12'h034, 12'h04c, 12'h064, 12'h07c, 12'h094,
    12'h0ac, 12'h0c4, 12'h300, 12'h318, 12'h400, 12'h418
  };

  typedef logic [PinsPerBank-1:0] word_t;

  typedef struct packed {
    word_t pad;
    word_t dir;
    word_t lat;
    word_t rise;
    word_t fall;
    word_t byp;
    word_t mask;
    word_t src;
    word_t typ;
    word_t pol;
    word_t wmask;
    word_t wsrc;
  } row_t;

  typedef struct packed {
    logic       hit;
    kind_e      kind;
    logic [2:0] bank;
  } dec_t;

endpackage

>>> design/gcw_decode.sv
// Address decoder from byte offset to register kind and bank.
module gcw_decode import gcw_pkg::*; #(
  parameter int unsigned NUM_BANKS = 6
) (
  input  logic [11:0] address_i,
  output dec_t        dec_o
);

  localparam logic [12:0] Span = 13'(4 * NUM_BANKS);

  logic [11:0] off;

  always_comb begin
    dec_o = '{hit: 1'b0, kind: KIND_LEVEL, bank: 3'd0};
    off   = '0;
    for (int k = KindCount - 1; k >= 0; k--) begin
      off = address_i - KindBase[k];
      if ({1'b0, address_i} >= {1'b0, KindBase[k]} &&
          {1'b0, address_i} < {1'b0, KindBase[k]} + Span &&
          off[1:0] == 2'b00) begin
        dec_o.hit  = 1'b1;
        dec_o.kind = kind_e'(4'(k));
        dec_o.bank = off[4:2];
      end
    end
  end

endmodule

>>> design/gcw_row_mem.sv
// Synchronous bank-row memory with per-row valid bits for reset.
module gcw_row_mem import gcw_pkg::*; #(
  parameter int unsigned DEPTH = 6,
  parameter int unsigned AW    = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  row_t          wr_data_i,
  output row_t          rd_data_o
);

  row_t             mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  row_t             rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/gpio_controller_with_interrupts_unit.sv
// Top level of the banked GPIO controller with edge and level interrupts.
// Usage: raise start with cmd_i and its operands while busy is low; the
// command is taken at that edge. Commands are bus read, bus write (byte
// offset on address_i) and pin sample of one bank (sample_bank_i and
// pad_levels_i). Each command returns one result: result_valid_o is high
// for one cycle, once the command has passed through busy_q and res_valid_q,
// with read_data_o, bad_address_o, irq_line_o, wake_line_o and the drive
// word of the bank. The bank row is read from the row memory as the command
// is taken and is modified and written back while busy is high, so busy is
// high for one cycle and a new command is taken only once it drops again.
// Results are not held; the receiver must take each one in its cycle.
// Reset clears every row through the per-row valid bits and clears the
// interrupt and wake flags; no clearing pass is needed and start is
// honored right after reset.
module gpio_controller_with_interrupts_unit import gcw_pkg::*; #(
  parameter int unsigned NUM_BANKS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [2:0]  sample_bank_i,
  input  logic [31:0] pad_levels_i,
  output logic        result_valid_o,
  output logic [31:0] read_data_o,
  output logic        bad_address_o,
  output logic        irq_line_o,
  output logic        wake_line_o,
  output logic [2:0]  drive_bank_o,
  output logic [31:0] drive_level_o,
  output logic [31:0] drive_enable_o
);

  localparam int unsigned BankW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  dec_t             dec;
  logic             accept;
  logic             have_d;
  logic [2:0]       bank_in;
  logic             busy_q;
  cmd_e             cmd_q;
  kind_e            kind_q;
  logic [BankW-1:0] bank_q;
  logic             have_q;
  logic             bad_q;
  word_t            data_q;
  word_t            pads_q;
  row_t             row;
  row_t             nrow;
  word_t            rd;
  word_t            edge_hits;
  word_t            hits;
  logic [NUM_BANKS-1:0] irq_flag_q, irq_flag_d;
  logic [NUM_BANKS-1:0] wake_flag_q, wake_flag_d;
  logic             res_valid_q;
  word_t            rd_q, lvl_q, en_q;
  logic             bad_res_q, irq_q, wake_q;
  logic [2:0]       db_q;

  gcw_decode #(.NUM_BANKS(NUM_BANKS)) u_decode (
    .address_i (address_i),
    .dec_o     (dec)
  );

  assign accept = start && !busy_q;

  always_comb begin
    have_d  = 1'b0;
    bank_in = 3'd0;
    case (cmd_e'(cmd_i))
      CMD_READ, CMD_WRITE: begin
        have_d  = dec.hit;
        bank_in = dec.bank;
      end
      CMD_SAMPLE: begin
        have_d  = {1'b0, sample_bank_i} < 4'(NUM_BANKS);
        bank_in = sample_bank_i;
      end
      default: begin
        have_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      irq_flag_q  <= '0;
      wake_flag_q <= '0;
    end else begin
      busy_q      <= accept;
      res_valid_q <= busy_q;
      irq_flag_q  <= irq_flag_d;
      wake_flag_q <= wake_flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      kind_q <= dec.kind;
      bank_q <= BankW'(bank_in);
      have_q <= have_d;
      bad_q  <= (cmd_e'(cmd_i) == CMD_READ || cmd_e'(cmd_i) == CMD_WRITE) && !dec.hit;
      data_q <= write_data_i;
      pads_q <= pad_levels_i;
    end
  end

  gcw_row_mem #(.DEPTH(NUM_BANKS), .AW(BankW)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (BankW'(bank_in)),
    .wr_en_i   (busy_q && have_q),
    .wr_addr_i (bank_q),
    .wr_data_i (nrow),
    .rd_data_o (row)
  );

  always_comb begin
    nrow      = row;
    rd        = '0;
    edge_hits = ((~row.pad & pads_q & row.rise) | (row.pad & ~pads_q & row.fall)) & ~row.typ;
    hits      = edge_hits | ((pads_q ^ row.pol) & row.typ);
    case (cmd_q)
      CMD_READ: begin
        case (kind_q)
          KIND_LEVEL:  rd = (row.dir & row.lat) | (~row.dir & row.pad);
          KIND_DIR:    rd = row.dir;
          KIND_RISE:   rd = row.rise;
          KIND_FALL:   rd = row.fall;
          KIND_BYPASS: rd = row.byp;
          KIND_MASK:   rd = row.mask;
          KIND_SRC:    rd = row.src;
          KIND_TYPE:   rd = row.typ;
          KIND_POL:    rd = row.pol;
          KIND_WMASK:  rd = row.wmask;
          KIND_WSRC:   rd = row.wsrc;
          default:     rd = '0;
        endcase
      end
      CMD_WRITE: begin
        case (kind_q)
          KIND_DIR:    nrow.dir   = data_q;
          KIND_SET:    nrow.lat   = row.lat | data_q;
          KIND_CLR:    nrow.lat   = row.lat & ~data_q;
          KIND_RISE:   nrow.rise  = data_q;
          KIND_FALL:   nrow.fall  = data_q;
          KIND_BYPASS: nrow.byp   = data_q;
          KIND_MASK:   nrow.mask  = data_q;
          KIND_SRC:    nrow.src   = row.src & ~data_q;
          KIND_TYPE:   nrow.typ   = data_q;
          KIND_POL:    nrow.pol   = data_q;
          KIND_WMASK:  nrow.wmask = data_q;
          KIND_WSRC:   nrow.wsrc  = row.wsrc & ~data_q;
          default:     nrow       = row;
        endcase
      end
      CMD_SAMPLE: begin
        nrow.src  = row.src | hits;
        nrow.wsrc = row.wsrc | (hits & row.wmask);
        nrow.pad  = pads_q;
      end
      default: begin
        nrow = row;
      end
    endcase
  end

  always_comb begin
    irq_flag_d  = irq_flag_q;
    wake_flag_d = wake_flag_q;
    if (busy_q && have_q) begin
      irq_flag_d[bank_q]  = |(nrow.src & nrow.mask);
      wake_flag_d[bank_q] = |nrow.wsrc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rd_q      <= have_q ? rd : '0;
      bad_res_q <= bad_q;
      irq_q     <= |irq_flag_d;
      wake_q    <= |wake_flag_d;
      db_q      <= have_q ? 3'(bank_q) : 3'd0;
      lvl_q     <= have_q ? nrow.lat : '0;
      en_q      <= have_q ? nrow.dir : '0;
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign read_data_o    = rd_q;
  assign bad_address_o  = bad_res_q;
  assign irq_line_o     = irq_q;
  assign wake_line_o    = wake_q;
  assign drive_bank_o   = db_q;
  assign drive_level_o  = lvl_q;
  assign drive_enable_o = en_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q) else $error("accepted transfer did not set busy");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> res_valid_q && !busy_q) else $error("result missing after busy");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !busy_q) else $error("result overlaps busy cycle");

  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && bad_q |-> !have_q) else $error("bad address marked as valid bank");

endmodule
